### hdl/b2dd_pkg.sv
// Shared types and constants for the binary to decimal digit converter.
package b2dd_pkg;

    localparam int NARROW_DIGITS_DEF = 10;
    localparam int WIDE_DIGITS_DEF   = 20;

    localparam int VALUE_W     = 64;
    localparam int NARROW_W    = 32;
    localparam int CHAR_W      = 6;
    localparam int BIT_CNT_W   = $clog2(VALUE_W + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic shift_last;
        logic digit_last;
    } status_t;

endpackage

### hdl/b2dd_datapath.sv
// Datapath: shift-and-add-3 conversion register and character output register.
module b2dd_datapath #(
    parameter int NARROW_DIGITS = b2dd_pkg::NARROW_DIGITS_DEF,
    parameter int WIDE_DIGITS   = b2dd_pkg::WIDE_DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  b2dd_pkg::cmd_t                cmd,
    output b2dd_pkg::status_t             status,
    input  logic [b2dd_pkg::VALUE_W-1:0]  in_value,
    input  logic                          in_mode,
    output logic [b2dd_pkg::CHAR_W-1:0]   out_char,
    output logic                          out_last
);
    import b2dd_pkg::*;

    localparam int BCD_W   = 4 * WIDE_DIGITS;
    localparam int DIG_CNT_W = $clog2(WIDE_DIGITS + 1);

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic                 wide_reg, wide_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic [3:0]           top_digit;

    // Each BCD digit of 5 or more gets 3 added before the shift; digits are independent.
    always_comb begin
        for (int i = 0; i < WIDE_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // The most significant digit of the run sits at the top of the narrow or wide field.
    assign top_digit = wide_reg ? bcd_reg[BCD_W-1 -: 4] : bcd_reg[4*NARROW_DIGITS-1 -: 4];

    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        wide_next    = wide_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        if (cmd.load) begin
            wide_next = in_mode;
            bcd_next  = '0;
            if (in_mode) begin
                bin_next     = in_value;
                bit_cnt_next = BIT_CNT_W'(VALUE_W);
                dig_cnt_next = DIG_CNT_W'(WIDE_DIGITS);
            end else begin
                // Narrow values are moved to the top so both modes shift out of bit 63.
                bin_next     = {in_value[NARROW_W-1:0], {(VALUE_W-NARROW_W){1'b0}}};
                bit_cnt_next = BIT_CNT_W'(NARROW_W);
                dig_cnt_next = DIG_CNT_W'(NARROW_DIGITS);
            end
        end else if (cmd.shift) begin
            bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
        end else if (cmd.emit) begin
            char_next    = ASCII_ZERO + {2'b00, top_digit};
            last_next    = (dig_cnt_reg == DIG_CNT_W'(1));
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'b0000};
            dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else begin
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        wide_reg <= wide_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.shift_last = (bit_cnt_reg == BIT_CNT_W'(1));
    assign status.digit_last = (dig_cnt_reg == DIG_CNT_W'(1));
    assign out_char = char_reg;
    assign out_last = last_reg;

endmodule

### hdl/b2dd_ctrl.sv
// Controller: sequences load, conversion shifts and character emission.
module b2dd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output b2dd_pkg::cmd_t     cmd,
    input  b2dd_pkg::status_t  status
);
    import b2dd_pkg::*;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                cmd.shift = 1'b1;
                if (status.shift_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    if (status.digit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = valid_reg;

endmodule

### hdl/binary_to_decimal_digits_core.sv
// Top level of the binary to decimal digit converter (binary to ASCII decimal text).
// Output: m_tvalid rises with the first character once the load and all conversion shifts
// are done; one character follows per cycle while the sink is ready.
// A new item is taken only in idle, after the last character of the previous one has entered
// the output register: the one-bit-per-cycle shift-and-add-3 loop and the output run in turn.
// Reset: aresetn is synchronous, active low, and returns the controller to idle with no
// character pending; the conversion registers need no clearing.
module binary_to_decimal_digits_core #(
    parameter int NARROW_DIGITS = b2dd_pkg::NARROW_DIGITS_DEF,
    parameter int WIDE_DIGITS   = b2dd_pkg::WIDE_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [0:0]  s_tuser,   // [0] mode
    // Result items, one ASCII digit character each.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] ascii_char, [7:6] zero
    output logic        m_tlast    // last_char
);
    import b2dd_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic [CHAR_W-1:0] out_char;

    // The controller walks each item through three phases: load, one shift per input
    // bit (32 or 64), then one character per cycle while the sink is ready, most significant first. The character
    // sits in an output register and is replaced only when the sink takes it.
    b2dd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // The datapath holds the binary shifter, the packed BCD register and the counters.
    // Leading digits stay zero, which gives the left padding with '0' characters.
    b2dd_datapath #(
        .NARROW_DIGITS (NARROW_DIGITS),
        .WIDE_DIGITS   (WIDE_DIGITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_value (s_tdata),
        .in_mode  (s_tuser[0]),
        .out_char (out_char),
        .out_last (m_tlast)
    );

    assign m_tdata = {2'b00, out_char};

endmodule

### verif/tb_binary_to_decimal_digits_core.sv
// Self-checking testbench for the binary to decimal digit converter.
module tb_binary_to_decimal_digits_core;

    import b2dd_pkg::*;

    // Width mode codes carried in tuser.
    localparam logic MODE_NARROW = 1'b0;
    localparam logic MODE_WIDE   = 1'b1;

    localparam int PAD_W          = 8 - CHAR_W;
    localparam int STALL_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 150;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              last_char;
    } digit_char_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    digit_char_t pending_chars[$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int report_count;
    int stall_cycles = 0;
    int items_sent;
    int narrow_items;
    int wide_items;
    int chars_checked;

    binary_to_decimal_digits_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Expected text of one conversion: the value is split into decimal digits
    // from the least significant end, so the run comes out zero padded.
    function automatic void predict_digit_run(input logic [63:0] value, input logic mode);
        longint unsigned rest;
        int              count;
        int              digits[WIDE_DIGITS_DEF];
        digit_char_t     c;
        if (mode == MODE_WIDE) begin
            count = WIDE_DIGITS_DEF;
            rest  = value;
        end else begin
            count = NARROW_DIGITS_DEF;
            rest  = {32'h0, value[NARROW_W-1:0]};
        end
        for (int k = count - 1; k >= 0; k--) begin
            digits[k] = int'(rest % 64'd10);
            rest      = rest / 64'd10;
        end
        for (int k = 0; k < count; k++) begin
            c.ascii_char = ASCII_ZERO + CHAR_W'(digits[k]);
            c.last_char  = (k == count - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [63:0] power_of_ten(input int exponent);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < exponent; k++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // Inputs change on the falling edge; the item counts as accepted at the
    // following rising edge where tready is seen high.
    task automatic send_number(input logic [63:0] value, input logic mode);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_digit_run(value, mode);
        items_sent++;
        if (mode == MODE_WIDE) begin
            wide_items++;
        end else begin
            narrow_items++;
        end
        @(negedge aclk);
    endtask

    // Holds the sender back until every predicted character has been seen.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic test_directed_extremes();
        send_number(64'd0, MODE_NARROW);
        send_number(64'd1, MODE_NARROW);
        send_number(64'd9, MODE_NARROW);
        send_number(64'd10, MODE_NARROW);
        send_number(64'd999_999_999, MODE_NARROW);
        send_number(64'd1_000_000_000, MODE_NARROW);
        send_number(64'h0000_0000_8000_0000, MODE_NARROW);
        send_number(64'h0000_0000_FFFF_FFFF, MODE_NARROW);
        send_number(64'h5555_5555_5555_5555, MODE_NARROW);
        send_number(64'd0, MODE_WIDE);
        send_number(64'd1, MODE_WIDE);
        send_number(64'h0000_0001_0000_0000, MODE_WIDE);
        send_number(64'h8000_0000_0000_0000, MODE_WIDE);
        send_number(power_of_ten(19) - 64'd1, MODE_WIDE);
        send_number(power_of_ten(19), MODE_WIDE);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_WIDE);
        send_number(64'hAAAA_AAAA_AAAA_AAAA, MODE_WIDE);
        send_number(64'h5555_5555_5555_5555, MODE_WIDE);
    endtask

    // In 32-bit mode the upper word must not leak into the text.
    task automatic test_upper_word_ignored();
        send_number(64'hFFFF_FFFF_0000_0000, MODE_NARROW);
        send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_NARROW);
        send_number(64'h8000_0001_0000_0009, MODE_NARROW);
        send_number(64'h1234_5678_3B9A_CA00, MODE_NARROW);
    endtask

    task automatic test_random_numbers(input int count);
        logic [63:0] value;
        logic        mode;
        int          pick;
        for (int n = 0; n < count; n++) begin
            mode = 1'($urandom_range(1));
            pick = $urandom_range(3);
            case (pick)
                0: begin
                    value = {$urandom, $urandom};
                end
                1: begin
                    // Random bit length, so short and long texts both appear.
                    value = {$urandom, $urandom} >> $urandom_range(63);
                end
                2: begin
                    // Around a decade boundary, where carries ripple through.
                    value = power_of_ten($urandom_range(19)) + 64'($urandom_range(2)) - 64'd1;
                end
                default: begin
                    value = 64'($urandom_range(99));
                end
            endcase
            send_number(value, mode);
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each accepted character is matched against the oldest prediction.
    always @(posedge aclk) begin : check_chars
        digit_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                fail_count++;
                if (report_count < REPORT_LIMIT) begin
                    $display("unexpected character: tdata=%h tlast=%b", m_tdata, m_tlast);
                end
                report_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_tdata !== {{PAD_W{1'b0}}, want.ascii_char} ||
                        m_tlast !== want.last_char) begin
                    fail_count++;
                    if (report_count < REPORT_LIMIT) begin
                        $display("mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                                 {{PAD_W{1'b0}}, want.ascii_char}, want.last_char,
                                 m_tdata, m_tlast);
                    end
                    report_count++;
                end
            end
        end
    end

    // Ends a hung run: too many cycles in a row without any handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 54;
        fail_count    = 0;
        report_count  = 0;
        items_sent    = 0;
        narrow_items  = 0;
        wide_items    = 0;
        chars_checked = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_extremes();
        test_upper_word_ignored();
        test_random_numbers(46);
        wait_drained();

        send_idle_pct = 54;
        recv_idle_pct = 7;
        test_random_numbers(46);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_numbers(46);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_chars.size() != 0) begin
            fail_count++;
        end

        $display("Converted %0d numbers (%0d in 32-bit mode, %0d in 64-bit mode).",
                 items_sent, narrow_items, wide_items);
        $display("Checked %0d digit characters under three back-pressure mixes, %0d errors.",
                 chars_checked, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hdl/b2dd_pkg.sv
hdl/b2dd_datapath.sv
hdl/b2dd_ctrl.sv
hdl/binary_to_decimal_digits_core.sv
verif/tb_binary_to_decimal_digits_core.sv
